@@ rtl/core/clcs_pkg.sv @@
// ----------------------------------------------------------------------------
// clcs_pkg
// Types, display opcodes and the control store of the character LCD cursor
// sequencer.
// ----------------------------------------------------------------------------
package clcs_pkg;

    typedef logic [2:0] cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] char_code;
    } req_item_t;

    typedef struct packed {
        logic       is_data;
        logic [7:0] bus_byte;
        logic       slow_wait;
        logic       startup_wait;
        logic       last;
    } wr_item_t;

    localparam cmd_t CMD_PUT_CHAR = 3'd0;
    localparam cmd_t CMD_CLEAR    = 3'd1;
    localparam cmd_t CMD_HOME     = 3'd2;
    localparam cmd_t CMD_CUR_ON   = 3'd3;
    localparam cmd_t CMD_CUR_OFF  = 3'd4;
    localparam cmd_t CMD_INIT     = 3'd5;

    localparam logic [7:0] CHAR_BS    = 8'd8;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    localparam logic [7:0] OP_CLEAR   = 8'b0000_0001;
    localparam logic [7:0] OP_HOME    = 8'b0000_0010;
    localparam logic [7:0] OP_ENTRY   = 8'b0000_0110;
    localparam logic [7:0] OP_CUR_OFF = 8'b0000_1100;
    localparam logic [7:0] OP_CUR_ON  = 8'b0000_1110;
    localparam logic [7:0] OP_LEFT    = 8'b0001_0000;
    localparam logic [7:0] OP_RIGHT   = 8'b0001_0100;
    localparam logic [7:0] OP_FUNCSET = 8'b0011_1100;
    localparam logic [7:0] OP_ROW0    = 8'b1000_0000;
    localparam logic [7:0] OP_ROW1    = 8'b1100_0000;

    typedef logic [1:0] sel_t;
    localparam sel_t SEL_CONST     = 2'd0;
    localparam sel_t SEL_CHAR      = 2'd1;
    localparam sel_t SEL_ROW_START = 2'd2;
    localparam sel_t SEL_ROW_OTHER = 2'd3;

    typedef logic [1:0] row_op_t;
    localparam row_op_t ROW_KEEP   = 2'd0;
    localparam row_op_t ROW_TOGGLE = 2'd1;
    localparam row_op_t ROW_ZERO   = 2'd2;

    typedef logic [1:0] col_op_t;
    localparam col_op_t COL_KEEP = 2'd0;
    localparam col_op_t COL_INC  = 2'd1;
    localparam col_op_t COL_DEC  = 2'd2;
    localparam col_op_t COL_ZERO = 2'd3;

    typedef logic [2:0] cond_t;
    localparam cond_t C_NEVER        = 3'd0;
    localparam cond_t C_ALWAYS       = 3'd1;
    localparam cond_t C_WRAP         = 3'd2;
    localparam cond_t C_COL0         = 3'd3;
    localparam cond_t C_PRELAST      = 3'd4;
    localparam cond_t C_CNT1         = 3'd5;
    localparam cond_t C_CNT0         = 3'd6;
    localparam cond_t C_PRELAST_CNT0 = 3'd7;

    typedef logic [4:0] pc_t;
    localparam pc_t PC_IDLE       = 5'd0;
    localparam pc_t PC_LFR_STEP   = 5'd1;
    localparam pc_t PC_LFR_WRAP   = 5'd2;
    localparam pc_t PC_LFL_TEST   = 5'd3;
    localparam pc_t PC_LFL_LEFT   = 5'd4;
    localparam pc_t PC_LFL_JUMP   = 5'd5;
    localparam pc_t PC_LFL_RIGHT  = 5'd6;
    localparam pc_t PC_BS_TEST1   = 5'd7;
    localparam pc_t PC_BS_LEFT1   = 5'd8;
    localparam pc_t PC_BS_JUMP1   = 5'd9;
    localparam pc_t PC_BS_RIGHT1  = 5'd10;
    localparam pc_t PC_BS_SPACE   = 5'd11;
    localparam pc_t PC_BS_WRAP    = 5'd12;
    localparam pc_t PC_BS_TEST2   = 5'd13;
    localparam pc_t PC_BS_LEFT2   = 5'd14;
    localparam pc_t PC_BS_JUMP2   = 5'd15;
    localparam pc_t PC_BS_RIGHT2  = 5'd16;
    localparam pc_t PC_PUT        = 5'd17;
    localparam pc_t PC_PUT_WRAP   = 5'd18;
    localparam pc_t PC_ROW_START  = 5'd19;
    localparam pc_t PC_CLEAR      = 5'd20;
    localparam pc_t PC_HOME       = 5'd21;
    localparam pc_t PC_CUR_ON     = 5'd22;
    localparam pc_t PC_CUR_OFF    = 5'd23;
    localparam pc_t PC_INIT_FUNC  = 5'd24;
    localparam pc_t PC_INIT_DISP  = 5'd25;
    localparam pc_t PC_INIT_ENTRY = 5'd26;

    typedef struct packed {
        logic       emit;
        logic       is_data;
        logic       slow;
        logic       startup;
        sel_t       sel;
        logic [7:0] const_byte;
        row_op_t    row_op;
        col_op_t    col_op;
        logic       cnt_dec;
        cond_t      c1;
        pc_t        t1;
        cond_t      c2;
        pc_t        t2;
        pc_t        t_else;
    } uword_t;

    typedef struct packed {
        logic wrap;
        logic col0;
        logic prelast;
        logic cnt1;
        logic cnt0;
    } status_t;

    function automatic uword_t rom_word(pc_t pc);
        uword_t w;
        w = '0;
        unique case (pc)
            PC_IDLE:
            begin
                w = '0;
            end
            PC_LFR_STEP:
            begin
                w.emit = 1'b1; w.const_byte = OP_RIGHT;
                w.col_op = COL_INC; w.cnt_dec = 1'b1;
                w.c1 = C_WRAP; w.t1 = PC_LFR_WRAP;
                w.c2 = C_CNT1; w.t2 = PC_IDLE;
                w.t_else = PC_LFR_STEP;
            end
            PC_LFR_WRAP:
            begin
                w.emit = 1'b1; w.sel = SEL_ROW_OTHER; w.row_op = ROW_TOGGLE;
                w.c1 = C_CNT0; w.t1 = PC_IDLE;
                w.t_else = PC_LFR_STEP;
            end
            PC_LFL_TEST:
            begin
                w.c1 = C_COL0; w.t1 = PC_LFL_JUMP;
                w.t_else = PC_LFL_LEFT;
            end
            PC_LFL_LEFT:
            begin
                w.emit = 1'b1; w.const_byte = OP_LEFT;
                w.col_op = COL_DEC; w.cnt_dec = 1'b1;
                w.c1 = C_CNT1; w.t1 = PC_IDLE;
                w.t_else = PC_LFL_TEST;
            end
            PC_LFL_JUMP:
            begin
                w.emit = 1'b1; w.sel = SEL_ROW_OTHER; w.row_op = ROW_TOGGLE;
                w.cnt_dec = 1'b1;
                w.t_else = PC_LFL_RIGHT;
            end
            PC_LFL_RIGHT:
            begin
                w.emit = 1'b1; w.const_byte = OP_RIGHT; w.col_op = COL_INC;
                w.c1 = C_PRELAST_CNT0; w.t1 = PC_IDLE;
                w.c2 = C_PRELAST; w.t2 = PC_LFL_TEST;
                w.t_else = PC_LFL_RIGHT;
            end
            PC_BS_TEST1:
            begin
                w.c1 = C_COL0; w.t1 = PC_BS_JUMP1;
                w.t_else = PC_BS_LEFT1;
            end
            PC_BS_LEFT1:
            begin
                w.emit = 1'b1; w.const_byte = OP_LEFT; w.col_op = COL_DEC;
                w.t_else = PC_BS_SPACE;
            end
            PC_BS_JUMP1:
            begin
                w.emit = 1'b1; w.sel = SEL_ROW_OTHER; w.row_op = ROW_TOGGLE;
                w.t_else = PC_BS_RIGHT1;
            end
            PC_BS_RIGHT1:
            begin
                w.emit = 1'b1; w.const_byte = OP_RIGHT; w.col_op = COL_INC;
                w.c1 = C_PRELAST; w.t1 = PC_BS_SPACE;
                w.t_else = PC_BS_RIGHT1;
            end
            PC_BS_SPACE:
            begin
                w.emit = 1'b1; w.is_data = 1'b1; w.const_byte = CHAR_SPACE;
                w.col_op = COL_INC;
                w.c1 = C_WRAP; w.t1 = PC_BS_WRAP;
                w.t_else = PC_BS_TEST2;
            end
            PC_BS_WRAP:
            begin
                w.emit = 1'b1; w.sel = SEL_ROW_OTHER; w.row_op = ROW_TOGGLE;
                w.t_else = PC_BS_TEST2;
            end
            PC_BS_TEST2:
            begin
                w.c1 = C_COL0; w.t1 = PC_BS_JUMP2;
                w.t_else = PC_BS_LEFT2;
            end
            PC_BS_LEFT2:
            begin
                w.emit = 1'b1; w.const_byte = OP_LEFT; w.col_op = COL_DEC;
                w.t_else = PC_IDLE;
            end
            PC_BS_JUMP2:
            begin
                w.emit = 1'b1; w.sel = SEL_ROW_OTHER; w.row_op = ROW_TOGGLE;
                w.t_else = PC_BS_RIGHT2;
            end
            PC_BS_RIGHT2:
            begin
                w.emit = 1'b1; w.const_byte = OP_RIGHT; w.col_op = COL_INC;
                w.c1 = C_PRELAST; w.t1 = PC_IDLE;
                w.t_else = PC_BS_RIGHT2;
            end
            PC_PUT:
            begin
                w.emit = 1'b1; w.is_data = 1'b1; w.sel = SEL_CHAR;
                w.col_op = COL_INC;
                w.c1 = C_WRAP; w.t1 = PC_PUT_WRAP;
                w.t_else = PC_IDLE;
            end
            PC_PUT_WRAP:
            begin
                w.emit = 1'b1; w.sel = SEL_ROW_OTHER; w.row_op = ROW_TOGGLE;
                w.t_else = PC_IDLE;
            end
            PC_ROW_START:
            begin
                w.emit = 1'b1; w.sel = SEL_ROW_START; w.col_op = COL_ZERO;
                w.t_else = PC_IDLE;
            end
            PC_CLEAR:
            begin
                w.emit = 1'b1; w.slow = 1'b1; w.const_byte = OP_CLEAR;
                w.t_else = PC_HOME;
            end
            PC_HOME:
            begin
                w.emit = 1'b1; w.slow = 1'b1; w.const_byte = OP_HOME;
                w.row_op = ROW_ZERO; w.col_op = COL_ZERO;
                w.t_else = PC_IDLE;
            end
            PC_CUR_ON:
            begin
                w.emit = 1'b1; w.const_byte = OP_CUR_ON;
                w.t_else = PC_IDLE;
            end
            PC_CUR_OFF:
            begin
                w.emit = 1'b1; w.const_byte = OP_CUR_OFF;
                w.t_else = PC_IDLE;
            end
            PC_INIT_FUNC:
            begin
                w.emit = 1'b1; w.startup = 1'b1; w.const_byte = OP_FUNCSET;
                w.t_else = PC_INIT_DISP;
            end
            PC_INIT_DISP:
            begin
                w.emit = 1'b1; w.const_byte = OP_CUR_OFF;
                w.t_else = PC_INIT_ENTRY;
            end
            PC_INIT_ENTRY:
            begin
                w.emit = 1'b1; w.slow = 1'b1; w.const_byte = OP_ENTRY;
                w.t_else = PC_CLEAR;
            end
            default:
            begin
                w = '0;
            end
        endcase
        return w;
    endfunction

    function automatic pc_t entry_pc(cmd_t cmd, logic [7:0] ch, logic row);
        pc_t pc;
        pc = PC_IDLE;
        unique case (cmd)
            CMD_PUT_CHAR:
            begin
                if (ch == CHAR_CR)
                    pc = PC_ROW_START;
                else if (ch == CHAR_LF)
                    pc = row ? PC_LFL_TEST : PC_LFR_STEP;
                else if (ch == CHAR_BS)
                    pc = PC_BS_TEST1;
                else
                    pc = PC_PUT;
            end
            CMD_CLEAR:   pc = PC_CLEAR;
            CMD_HOME:    pc = PC_ROW_START;
            CMD_CUR_ON:  pc = PC_CUR_ON;
            CMD_CUR_OFF: pc = PC_CUR_OFF;
            CMD_INIT:    pc = PC_INIT_FUNC;
            default:     pc = PC_IDLE;
        endcase
        return pc;
    endfunction

endpackage

@@ rtl/core/char_lcd_cursor_sequencer.sv @@
// ----------------------------------------------------------------------------
// char_lcd_cursor_sequencer
// Each request item (put char, clear, home, cursor on/off, initialise) is
// turned into a run of display bus write items while the cursor row and
// column are tracked for a two-row display of COLUMNS columns. A request is
// taken only when the previous one has issued all its writes. Each write is
// one step of the sequencer, and every left move (backspace, line feed on the
// lower row) adds a decision step with no write, a line feed on the lower
// row keeping the sequencer busy longest. The microcoded step counter sets
// the pace and issues at most one write per cycle into a single output
// register, none while that register holds a write not yet taken; unused
// command codes are taken and produce no writes.
// ----------------------------------------------------------------------------
module char_lcd_cursor_sequencer
#(
    parameter int COLUMNS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  clcs_pkg::req_item_t   req_item,
    output logic                  wr_valid,
    input  logic                  wr_ready,
    output clcs_pkg::wr_item_t    wr_item
);

    logic                 start;
    logic                 busy;
    logic                 seq_step;
    logic                 seq_last;
    logic                 slot_free;
    logic                 row;
    logic [7:0]           bus_byte;
    logic [7:0]           char_reg;
    logic                 wr_valid_reg;
    clcs_pkg::wr_item_t   wr_item_reg;
    clcs_pkg::pc_t        entry;
    clcs_pkg::uword_t     uword;
    clcs_pkg::status_t    status;

    assign req_ready = !busy;
    assign start     = req_valid && req_ready;
    assign slot_free = !wr_valid_reg || wr_ready;
    assign entry     = clcs_pkg::entry_pc(req_item.cmd, req_item.char_code, row);

    clcs_sequencer u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .entry     (entry),
        .status    (status),
        .slot_free (slot_free),
        .busy      (busy),
        .step      (seq_step),
        .last      (seq_last),
        .uword     (uword)
    );

    clcs_cursor #(.COLUMNS(COLUMNS)) u_cursor
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .step      (seq_step),
        .uword     (uword),
        .char_code (char_reg),
        .row       (row),
        .status    (status),
        .bus_byte  (bus_byte)
    );

    always_ff @(posedge clk)
    begin
        if (start)
            char_reg <= req_item.char_code;
        if (seq_step && uword.emit)
        begin
            wr_item_reg.is_data      <= uword.is_data;
            wr_item_reg.bus_byte     <= bus_byte;
            wr_item_reg.slow_wait    <= uword.slow;
            wr_item_reg.startup_wait <= uword.startup;
            wr_item_reg.last         <= seq_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wr_valid_reg <= 1'b0;
        else if (seq_step && uword.emit)
            wr_valid_reg <= 1'b1;
        else if (wr_ready)
            wr_valid_reg <= 1'b0;
    end

    assign wr_valid = wr_valid_reg;
    assign wr_item  = wr_item_reg;

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_step && uword.emit && seq_last) |=> req_ready)
        else $error("Final write of a request did not return the sequencer to idle.");

    a_ignored_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && entry == clcs_pkg::PC_IDLE) |=> (req_ready && $stable(row)))
        else $error("Unused command code started a write run.");

endmodule

@@ rtl/core/clcs_sequencer.sv @@
// ----------------------------------------------------------------------------
// clcs_sequencer
// Step counter and control store: fetches one control word per step and
// picks the next step from two prioritised conditional jumps.
// ----------------------------------------------------------------------------
module clcs_sequencer
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  clcs_pkg::pc_t      entry,
    input  clcs_pkg::status_t  status,
    input  logic               slot_free,
    output logic               busy,
    output logic               step,
    output logic               last,
    output clcs_pkg::uword_t   uword
);

    clcs_pkg::pc_t pc_reg;
    clcs_pkg::pc_t pc_next;
    clcs_pkg::pc_t branch_pc;

    function automatic logic cond_true(clcs_pkg::cond_t c, clcs_pkg::status_t s);
        logic r;
        r = 1'b0;
        case (c)
            clcs_pkg::C_NEVER:        r = 1'b0;
            clcs_pkg::C_ALWAYS:       r = 1'b1;
            clcs_pkg::C_WRAP:         r = s.wrap;
            clcs_pkg::C_COL0:         r = s.col0;
            clcs_pkg::C_PRELAST:      r = s.prelast;
            clcs_pkg::C_CNT1:         r = s.cnt1;
            clcs_pkg::C_CNT0:         r = s.cnt0;
            clcs_pkg::C_PRELAST_CNT0: r = s.prelast && s.cnt0;
            default:                  r = 1'b0;
        endcase
        return r;
    endfunction

    always_comb
    begin
        uword = clcs_pkg::rom_word(pc_reg);
        if (cond_true(uword.c1, status))
            branch_pc = uword.t1;
        else if (cond_true(uword.c2, status))
            branch_pc = uword.t2;
        else
            branch_pc = uword.t_else;
        busy = (pc_reg != clcs_pkg::PC_IDLE);
        step = busy && (!uword.emit || slot_free);
        last = uword.emit && (branch_pc == clcs_pkg::PC_IDLE);
        if (start)
            pc_next = entry;
        else if (step)
            pc_next = branch_pc;
        else
            pc_next = pc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= clcs_pkg::PC_IDLE;
        else
            pc_reg <= pc_next;
    end

endmodule

@@ rtl/core/clcs_cursor.sv @@
// ----------------------------------------------------------------------------
// clcs_cursor
// Cursor datapath: row, column and step count registers, the status flags
// tested by the sequencer and the byte placed on the display bus.
// ----------------------------------------------------------------------------
module clcs_cursor
#(
    parameter int COLUMNS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               step,
    input  clcs_pkg::uword_t   uword,
    input  logic [7:0]         char_code,
    output logic               row,
    output clcs_pkg::status_t  status,
    output logic [7:0]         bus_byte
);

    localparam int COL_W = $clog2(COLUMNS);
    localparam int CNT_W = $clog2(COLUMNS + 1);

    logic             row_reg;
    logic             row_next;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_comb
    begin
        status.wrap    = (col_reg == COL_W'(COLUMNS - 1));
        status.col0    = (col_reg == '0);
        status.prelast = (col_reg == COL_W'(COLUMNS - 2));
        status.cnt1    = (cnt_reg == CNT_W'(1));
        status.cnt0    = (cnt_reg == '0);

        row_next = row_reg;
        col_next = col_reg;
        cnt_next = cnt_reg;
        if (start)
            cnt_next = CNT_W'(COLUMNS);
        if (step)
        begin
            case (uword.row_op)
                clcs_pkg::ROW_TOGGLE: row_next = ~row_reg;
                clcs_pkg::ROW_ZERO:   row_next = 1'b0;
                default:              row_next = row_reg;
            endcase
            case (uword.col_op)
                clcs_pkg::COL_INC:  col_next = status.wrap ? '0 : col_reg + 1'b1;
                clcs_pkg::COL_DEC:  col_next = col_reg - 1'b1;
                clcs_pkg::COL_ZERO: col_next = '0;
                default:            col_next = col_reg;
            endcase
            if (uword.cnt_dec)
                cnt_next = cnt_reg - 1'b1;
        end

        case (uword.sel)
            clcs_pkg::SEL_CHAR:      bus_byte = char_code;
            clcs_pkg::SEL_ROW_START: bus_byte = row_reg ? clcs_pkg::OP_ROW1
                                                        : clcs_pkg::OP_ROW0;
            clcs_pkg::SEL_ROW_OTHER: bus_byte = row_reg ? clcs_pkg::OP_ROW0
                                                        : clcs_pkg::OP_ROW1;
            default:                 bus_byte = uword.const_byte;
        endcase
    end

    assign row = row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= 1'b0;
            col_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
            cnt_reg <= cnt_next;
        end
    end

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= COL_W'(COLUMNS - 1))
        else $error("Cursor column beyond the last column.");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(COLUMNS))
        else $error("Step count beyond the row length.");

    a_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        (step && uword.row_op == clcs_pkg::ROW_TOGGLE) |=> (row_reg != $past(row_reg)))
        else $error("Row jump did not change the row.");

endmodule

@@ verif/clcs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcs_checker
// Watches the request and write channels of the character LCD cursor
// sequencer. It keeps its own copy of the cursor row and column, and expands
// every accepted request into the display writes it must cause. It then
// compares each accepted write, field by field, with the oldest write still
// due. Mismatches and writes with nothing due are counted as failures.
// ----------------------------------------------------------------------------
module clcs_checker
#(
    parameter int COLUMNS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  logic                  req_ready,
    input  clcs_pkg::req_item_t   req_item,
    input  logic                  wr_valid,
    input  logic                  wr_ready,
    input  clcs_pkg::wr_item_t    wr_item,
    output int                    fail_count,
    output int                    pending,
    output int                    req_count,
    output int                    wr_count
);

    localparam int MAX_WRITES = 2 * COLUMNS + 2;

    logic               disp_row;
    int                 disp_col;
    clcs_pkg::wr_item_t burst[$];
    clcs_pkg::wr_item_t writes_due[$];
    clcs_pkg::wr_item_t due;
    int                 fails = 0;
    int                 due_count = 0;
    int                 req_total = 0;
    int                 wr_total = 0;

    assign fail_count = fails;
    assign pending    = due_count;
    assign req_count  = req_total;
    assign wr_count   = wr_total;

    function automatic void add_write(logic is_data, logic [7:0] b, logic slow,
                                      logic startup);
        clcs_pkg::wr_item_t w;
        if (burst.size() < MAX_WRITES)
        begin
            w.is_data      = is_data;
            w.bus_byte     = b;
            w.slow_wait    = slow;
            w.startup_wait = startup;
            w.last         = 1'b0;
            burst.push_back(w);
        end
    endfunction

    function automatic void swap_row();
        add_write(1'b0, disp_row ? clcs_pkg::OP_ROW0 : clcs_pkg::OP_ROW1, 1'b0, 1'b0);
        disp_row = ~disp_row;
    endfunction

    function automatic void move_right();
        add_write(1'b0, clcs_pkg::OP_RIGHT, 1'b0, 1'b0);
        disp_col++;
        if (disp_col >= COLUMNS)
        begin
            disp_col = 0;
            swap_row();
        end
    endfunction

    // A left move from the first column lands at the far end of the other
    // row by stepping right across it.
    function automatic void move_left();
        if (disp_col == 0)
        begin
            swap_row();
            for (int i = 0; i < COLUMNS - 1; i++)
                move_right();
        end
        else
        begin
            disp_col--;
            add_write(1'b0, clcs_pkg::OP_LEFT, 1'b0, 1'b0);
        end
    endfunction

    function automatic void write_char(logic [7:0] b);
        add_write(1'b1, b, 1'b0, 1'b0);
        disp_col++;
        if (disp_col >= COLUMNS)
        begin
            disp_col = 0;
            swap_row();
        end
    endfunction

    function automatic void go_row_start();
        add_write(1'b0, disp_row ? clcs_pkg::OP_ROW1 : clcs_pkg::OP_ROW0, 1'b0, 1'b0);
        disp_col = 0;
    endfunction

    function automatic void clear_display();
        add_write(1'b0, clcs_pkg::OP_CLEAR, 1'b1, 1'b0);
        add_write(1'b0, clcs_pkg::OP_HOME, 1'b1, 1'b0);
        disp_row = 1'b0;
        disp_col = 0;
    endfunction

    function automatic void predict_writes(clcs_pkg::req_item_t r);
        clcs_pkg::wr_item_t w;
        logic               from_lower;
        burst.delete();
        case (r.cmd)
            clcs_pkg::CMD_PUT_CHAR:
            begin
                if (r.char_code == clcs_pkg::CHAR_CR)
                    go_row_start();
                else if (r.char_code == clcs_pkg::CHAR_LF)
                begin
                    from_lower = disp_row;
                    for (int i = 0; i < COLUMNS; i++)
                    begin
                        if (from_lower == 1'b0)
                            move_right();
                        else
                            move_left();
                    end
                end
                else if (r.char_code == clcs_pkg::CHAR_BS)
                begin
                    move_left();
                    write_char(clcs_pkg::CHAR_SPACE);
                    move_left();
                end
                else
                    write_char(r.char_code);
            end
            clcs_pkg::CMD_CLEAR:   clear_display();
            clcs_pkg::CMD_HOME:    go_row_start();
            clcs_pkg::CMD_CUR_ON:  add_write(1'b0, clcs_pkg::OP_CUR_ON, 1'b0, 1'b0);
            clcs_pkg::CMD_CUR_OFF: add_write(1'b0, clcs_pkg::OP_CUR_OFF, 1'b0, 1'b0);
            clcs_pkg::CMD_INIT:
            begin
                add_write(1'b0, clcs_pkg::OP_FUNCSET, 1'b0, 1'b1);
                add_write(1'b0, clcs_pkg::OP_CUR_OFF, 1'b0, 1'b0);
                add_write(1'b0, clcs_pkg::OP_ENTRY, 1'b1, 1'b0);
                clear_display();
            end
            default:
            begin
            end
        endcase
        if (burst.size() > 0)
        begin
            w = burst.pop_back();
            w.last = 1'b1;
            burst.push_back(w);
        end
        foreach (burst[i])
            writes_due.push_back(burst[i]);
    endfunction

    function automatic void compare_field(string name, logic [7:0] want,
                                          logic [7:0] got);
        if (got !== want)
        begin
            $error("write field %s: expected %0h, actual %0h", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            disp_row = 1'b0;
            disp_col = 0;
            writes_due.delete();
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                req_total++;
                predict_writes(req_item);
            end
            if (wr_valid && wr_ready)
            begin
                wr_total++;
                if (writes_due.size() == 0)
                begin
                    $error("write item with nothing due: bus_byte %0h", wr_item.bus_byte);
                    fails++;
                end
                else
                begin
                    due = writes_due.pop_front();
                    compare_field("is_data", 8'(due.is_data), 8'(wr_item.is_data));
                    compare_field("bus_byte", due.bus_byte, wr_item.bus_byte);
                    compare_field("slow_wait", 8'(due.slow_wait), 8'(wr_item.slow_wait));
                    compare_field("startup_wait", 8'(due.startup_wait),
                                  8'(wr_item.startup_wait));
                    compare_field("last", 8'(due.last), 8'(wr_item.last));
                end
            end
        end
        due_count = writes_due.size();
    end

endmodule

@@ verif/tb_char_lcd_cursor_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_char_lcd_cursor_sequencer
// Drives requests into the character LCD cursor sequencer: a short directed
// list that covers every command and the wrap cases, then random
// requests in four idling phases on both channels. The checker beside the
// block predicts and compares the write items. This module gives the verdict.
// ----------------------------------------------------------------------------
module tb_char_lcd_cursor_sequencer;

    localparam int COLUMNS     = 16;
    localparam int RANDOM_REQS = 500;
    localparam int DRAIN       = 3 * COLUMNS + 10;
    localparam int CYCLE_LIMIT = 600000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    clcs_pkg::req_item_t req_item = '0;
    logic                wr_valid;
    logic                wr_ready = 1'b0;
    clcs_pkg::wr_item_t  wr_item;

    int fail_count;
    int pending;
    int req_count;
    int wr_count;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycle = 0;

    always #1 clk = ~clk;

    char_lcd_cursor_sequencer #(.COLUMNS(COLUMNS)) DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_item  (req_item),
        .wr_valid  (wr_valid),
        .wr_ready  (wr_ready),
        .wr_item   (wr_item)
    );

    clcs_checker #(.COLUMNS(COLUMNS)) u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_item   (req_item),
        .wr_valid   (wr_valid),
        .wr_ready   (wr_ready),
        .wr_item    (wr_item),
        .fail_count (fail_count),
        .pending    (pending),
        .req_count  (req_count),
        .wr_count   (wr_count)
    );

    always @(posedge clk)
        wr_ready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic send_request(clcs_pkg::cmd_t cmd, logic [7:0] ch);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid          <= 1'b1;
        req_item.cmd       <= cmd;
        req_item.char_code <= ch;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    // Mostly characters and cursor controls, so the cursor wanders over both
    // rows and wraps often; now and then a screen command or an unused code.
    task automatic send_random_request();
        int         pick;
        logic [7:0] ch;
        pick = $urandom_range(99);
        ch   = 8'($urandom_range(255));
        if (pick < 50)
            send_request(clcs_pkg::CMD_PUT_CHAR, ch);
        else if (pick < 60)
            send_request(clcs_pkg::CMD_PUT_CHAR, clcs_pkg::CHAR_CR);
        else if (pick < 70)
            send_request(clcs_pkg::CMD_PUT_CHAR, clcs_pkg::CHAR_LF);
        else if (pick < 80)
            send_request(clcs_pkg::CMD_PUT_CHAR, clcs_pkg::CHAR_BS);
        else if (pick < 84)
            send_request(clcs_pkg::CMD_CLEAR, ch);
        else if (pick < 88)
            send_request(clcs_pkg::CMD_HOME, ch);
        else if (pick < 92)
            send_request(clcs_pkg::CMD_CUR_ON, ch);
        else if (pick < 96)
            send_request(clcs_pkg::CMD_CUR_OFF, ch);
        else if (pick < 98)
            send_request(clcs_pkg::CMD_INIT, ch);
        else
            send_request(clcs_pkg::cmd_t'($urandom_range(6, 7)), ch);
    endtask

    initial
    begin
        while (cycle < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle++;
        end
        $display("tb_char_lcd_cursor_sequencer: errors");
        $finish;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(clcs_pkg::CMD_INIT, 8'hFF);
        send_request(clcs_pkg::CMD_CUR_ON, 8'h00);
        send_request(clcs_pkg::CMD_CUR_OFF, 8'hFF);
        // Backspace at the very first position causes the most writes.
        send_request(clcs_pkg::CMD_PUT_CHAR, clcs_pkg::CHAR_BS);
        send_request(clcs_pkg::CMD_PUT_CHAR, clcs_pkg::CHAR_LF);
        send_request(clcs_pkg::CMD_PUT_CHAR, clcs_pkg::CHAR_LF);
        send_request(clcs_pkg::CMD_PUT_CHAR, 8'h00);
        send_request(clcs_pkg::CMD_PUT_CHAR, 8'hFF);
        send_request(clcs_pkg::CMD_PUT_CHAR, 8'h55);
        send_request(clcs_pkg::CMD_PUT_CHAR, 8'hAA);
        send_request(clcs_pkg::CMD_PUT_CHAR, clcs_pkg::CHAR_CR);
        send_request(clcs_pkg::CMD_PUT_CHAR, clcs_pkg::CHAR_LF);
        send_request(clcs_pkg::CMD_PUT_CHAR, 8'h41);
        send_request(clcs_pkg::CMD_PUT_CHAR, clcs_pkg::CHAR_BS);
        send_request(clcs_pkg::CMD_PUT_CHAR, clcs_pkg::CHAR_BS);
        send_request(clcs_pkg::CMD_HOME, 8'h0D);
        send_request(clcs_pkg::cmd_t'(6), 8'h41);
        send_request(clcs_pkg::cmd_t'(7), 8'hFF);
        send_request(clcs_pkg::CMD_PUT_CHAR, clcs_pkg::CHAR_LF);
        send_request(clcs_pkg::CMD_PUT_CHAR, clcs_pkg::CHAR_LF);
        send_request(clcs_pkg::CMD_CLEAR, 8'h08);
        send_request(clcs_pkg::CMD_PUT_CHAR, clcs_pkg::CHAR_SPACE);

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = (phase == 1) ? 52 : (phase == 3) ? 34 : 0;
            recv_stall_pct = (phase == 2) ? 52 : (phase == 3) ? 34 : 0;
            for (int n = 0; n < RANDOM_REQS / 4; n++)
                send_random_request();
        end
        req_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("Requests accepted: %0d, display writes checked: %0d.", req_count, wr_count);
        $display("Idling phases: none, sender idle, receiver stalling, both.");
        if (fail_count == 0 && pending == 0)
            $display("tb_char_lcd_cursor_sequencer: clean");
        else
            $display("tb_char_lcd_cursor_sequencer: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/clcs_pkg.sv
rtl/core/clcs_sequencer.sv
rtl/core/clcs_cursor.sv
rtl/core/char_lcd_cursor_sequencer.sv
verif/clcs_checker.sv
verif/tb_char_lcd_cursor_sequencer.sv
